// ===== hdl/oav_pkg.sv =====
// Shared constants, codes and types for the oscillator/ADSR voice.
// No dependencies; imported by every module of the voice.
`default_nettype none

package oav_pkg;

  // Default parameter values
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned COUNT_WIDTH_DEF  = 32;

  // Field widths
  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned LEN_W    = 24;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned WAVE_W   = 2;
  localparam int unsigned STAGE_W  = 3;
  localparam int unsigned LFSR_W   = 32;
  localparam logic [LFSR_W-1:0] LFSR_MASK = 32'h8020_0003;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 32'h0000_0001;

  // Serial multiplier: AW-bit multiplicand, one multiplier bit per cycle
  localparam int unsigned MUL_AW = 33;
  localparam int unsigned MUL_BW = 16;
  localparam int unsigned MUL_PW = MUL_AW + MUL_BW;
  localparam int unsigned MUL_CW = $clog2(MUL_BW);

  // Serial divider: quotient known to fit in DIV_QW bits
  localparam int unsigned DIV_DW = 35;
  localparam int unsigned DIV_QW = 17;
  localparam int unsigned DIV_NW = DIV_DW + DIV_QW;
  localparam int unsigned DIV_CW = $clog2(DIV_QW);

  // Register map (word index)
  localparam int unsigned REG_AW = 3;
  localparam logic [REG_AW-1:0] REG_ATTACK_LEVEL   = 3'd0;
  localparam logic [REG_AW-1:0] REG_ATTACK_LENGTH  = 3'd1;
  localparam logic [REG_AW-1:0] REG_DECAY_LEVEL    = 3'd2;
  localparam logic [REG_AW-1:0] REG_DECAY_LENGTH   = 3'd3;
  localparam logic [REG_AW-1:0] REG_SUSTAIN_LEVEL  = 3'd4;
  localparam logic [REG_AW-1:0] REG_RELEASE_LEVEL  = 3'd5;
  localparam logic [REG_AW-1:0] REG_RELEASE_LENGTH = 3'd6;
  localparam logic [REG_AW-1:0] REG_VOICE_GAIN     = 3'd7;

  // Item opcodes
  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_NOTE_ON = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

  // Waveforms
  localparam logic [WAVE_W-1:0] WAVE_SQUARE = 2'd0;
  localparam logic [WAVE_W-1:0] WAVE_SAW    = 2'd1;
  localparam logic [WAVE_W-1:0] WAVE_SINE   = 2'd2;
  localparam logic [WAVE_W-1:0] WAVE_NOISE  = 2'd3;

  // Envelope stages
  typedef enum logic [STAGE_W-1:0] {
    ENV_ATTACK  = 3'd0,
    ENV_DECAY   = 3'd1,
    ENV_SUSTAIN = 3'd2,
    ENV_RELEASE = 3'd3,
    ENV_END     = 3'd4
  } env_stage_e;

endpackage

`default_nettype wire

// ===== hdl/oav_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on oav_pkg for operand widths.
`default_nettype none

module oav_mul import oav_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MUL_AW-1:0] a_i,
  input  logic [MUL_BW-1:0] b_i,
  output logic              done_o,
  output logic              busy_o,
  output logic [MUL_PW-1:0] prod_o
);

  logic [MUL_AW-1:0] a_q;
  logic [MUL_AW-1:0] hi_q, hi_d;
  logic [MUL_BW-1:0] lo_q, lo_d;
  logic [MUL_CW-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [MUL_AW:0]   sum;

  // add the multiplicand when the current multiplier bit is set, then shift
  always_comb begin
    sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
    hi_d = sum[MUL_AW:1];
    lo_d = {sum[0], lo_q[MUL_BW-1:1]};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == MUL_CW'(MUL_BW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign done_o = done_q;
  assign busy_o = busy_q;
  assign prod_o = {hi_q, lo_q};

endmodule

`default_nettype wire

// ===== hdl/oav_div.sv =====
// Restoring divider, one quotient bit per cycle; the quotient must fit DIV_QW bits.
// Depends on oav_pkg for operand widths.
`default_nettype none

module oav_div import oav_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_NW-1:0] num_i,
  input  logic [DIV_DW-1:0] den_i,
  output logic              done_o,
  output logic              busy_o,
  output logic [DIV_QW-1:0] quot_o
);

  logic [DIV_DW-1:0] rem_q, rem_d;
  logic [DIV_DW-1:0] den_q;
  logic [DIV_QW-1:0] qs_q, qs_d;
  logic [DIV_CW-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [DIV_DW:0]   trial;
  logic              ge;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_q, qs_q[DIV_QW-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
    qs_d  = {qs_q[DIV_QW-2:0], ge};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CW'(DIV_QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: remainder starts from the high dividend bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[DIV_NW-1:DIV_QW];
      qs_q  <= num_i[DIV_QW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      qs_q  <= qs_d;
    end
  end

  assign done_o = done_q;
  assign busy_o = busy_q;
  assign quot_o = qs_q;

endmodule

`default_nettype wire

// ===== hdl/oscillator_adsr_voice_unit.sv =====
// One synthesizer voice: a tick item yields one sample of oscillator x gain x ADSR
// envelope. Items are note on (opcode in tuser), release and tick; only a tick
// gives an output transfer. Non-tick items are applied when they are taken. A tick is worked
// out by a sequencer over one shared bit-serial multiplier and one shared restoring
// divider: 2 products plus 1 quotient for the envelope ramp, 1 more quotient for saw
// and 2 products plus 1 quotient for the half-sine. A finished sample waits in the
// output register while the next item is taken.
// Depends on oav_pkg, oav_mul and oav_div.
`default_nettype none

module oscillator_adsr_voice_unit import oav_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH  = COUNT_WIDTH_DEF,
  localparam int unsigned OUT_TDW     = ((SAMPLE_WIDTH + STAGE_W + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // item stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,  // note_period[15:0], wave_select[17:16]
  input  logic [OP_W-1:0]    s_axis_tuser,  // op[1:0]
  // sample stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [OUT_TDW-1:0] m_axis_tdata,  // sample_out, stage above it
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned CW = COUNT_WIDTH;
  localparam int unsigned WW = ((CW > LEN_W) ? CW : LEN_W) + 1;
  localparam int unsigned SHIFT = 46 - SW;
  localparam logic [CW-1:0] COUNT_MAX = '1;
  localparam logic [MUL_PW-1:0] LIM = MUL_PW'(1) << (SW - 1);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_OSC   = 12'b0000_0000_0010,
    ST_QMUL  = 12'b0000_0000_0100,
    ST_LMUL  = 12'b0000_0000_1000,
    ST_SDIV  = 12'b0000_0001_0000,
    ST_ENV   = 12'b0000_0010_0000,
    ST_RMUL1 = 12'b0000_0100_0000,
    ST_RMUL2 = 12'b0000_1000_0000,
    ST_RDIV  = 12'b0001_0000_0000,
    ST_GMUL  = 12'b0010_0000_0000,
    ST_AMUL  = 12'b0100_0000_0000,
    ST_OUT   = 12'b1000_0000_0000
  } seq_state_e;

  function automatic logic [LEN_W-1:0] len_of(input logic [LEN_W-1:0] v);
    return (v == '0) ? LEN_W'(1) : v;
  endfunction

  // ---------------- configuration registers ----------------
  logic [LEVEL_W-1:0] attack_level_q, decay_level_q, sustain_level_q;
  logic [LEVEL_W-1:0] release_level_q, voice_gain_q;
  logic [LEN_W-1:0]   attack_length_q, decay_length_q, release_length_q;
  logic               cfg_wr;
  logic [REG_AW-1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_level_q   <= 16'd32768;
      attack_length_q  <= 24'd4800;
      decay_level_q    <= 16'd16384;
      decay_length_q   <= 24'd4800;
      sustain_level_q  <= 16'd16384;
      release_level_q  <= 16'd0;
      release_length_q <= 24'd4800;
      voice_gain_q     <= 16'd32768;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ATTACK_LEVEL:   attack_level_q   <= pwdata[LEVEL_W-1:0];
        REG_ATTACK_LENGTH:  attack_length_q  <= pwdata[LEN_W-1:0];
        REG_DECAY_LEVEL:    decay_level_q    <= pwdata[LEVEL_W-1:0];
        REG_DECAY_LENGTH:   decay_length_q   <= pwdata[LEN_W-1:0];
        REG_SUSTAIN_LEVEL:  sustain_level_q  <= pwdata[LEVEL_W-1:0];
        REG_RELEASE_LEVEL:  release_level_q  <= pwdata[LEVEL_W-1:0];
        REG_RELEASE_LENGTH: release_length_q <= pwdata[LEN_W-1:0];
        REG_VOICE_GAIN:     voice_gain_q     <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_ATTACK_LEVEL:   prdata = 32'(attack_level_q);
      REG_ATTACK_LENGTH:  prdata = 32'(attack_length_q);
      REG_DECAY_LEVEL:    prdata = 32'(decay_level_q);
      REG_DECAY_LENGTH:   prdata = 32'(decay_length_q);
      REG_SUSTAIN_LEVEL:  prdata = 32'(sustain_level_q);
      REG_RELEASE_LEVEL:  prdata = 32'(release_level_q);
      REG_RELEASE_LENGTH: prdata = 32'(release_length_q);
      REG_VOICE_GAIN:     prdata = 32'(voice_gain_q);
      default:            prdata = '0;
    endcase
  end

  // ---------------- state ----------------
  seq_state_e          state_q, state_d;
  logic                issued_q, issued_d;
  logic [CW-1:0]       count_q, count_d;
  logic [PERIOD_W-1:0] phase_q, phase_d;
  logic [PERIOD_W-1:0] period_q, period_d;
  logic [WAVE_W-1:0]   wave_q, wave_d;
  env_stage_e          env_q, env_d;
  logic [CW-1:0]       rstart_q, rstart_d;
  logic                pend_q, pend_d;
  logic [LFSR_W-1:0]   lfsr_q, lfsr_d;
  logic                out_valid_q, out_valid_d;
  logic [SW-1:0]       out_sample_q, out_sample_d;
  logic [STAGE_W-1:0]  out_stage_q, out_stage_d;

  // working registers of one tick
  logic [16:0]         osc_mag_q, osc_mag_d;
  logic                osc_neg_q, osc_neg_d;
  logic [LEVEL_W-1:0]  amp_q, amp_d;
  logic [STAGE_W-1:0]  stage_now_q, stage_now_d;
  logic [LEVEL_W-1:0]  r_from_q, r_from_d, r_to_q, r_to_d;
  logic [LEN_W-1:0]    r_len_q, r_len_d, r_e_q, r_e_d;
  logic [MUL_PW-1:0]   acc_q, acc_d;
  logic [31:0]         sq_q, sq_d;
  logic [DIV_DW-1:0]   sden_q, sden_d;
  logic [SW-1:0]       res_q, res_d;

  // ---------------- shared arithmetic units ----------------
  logic              mul_start, mul_done, mul_busy;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] mul_prod;
  logic              div_start, div_done, div_busy;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic [DIV_QW-1:0] div_quot;

  oav_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .busy_o  (mul_busy),
    .prod_o  (mul_prod)
  );

  oav_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  // operand select per sequencer step; a unit starts once on entry to its step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_num = '0;
    div_den = '0;
    unique case (state_q)
      ST_QMUL:  begin mul_a = MUL_AW'(period_q - phase_q); mul_b = phase_q; end
      ST_LMUL:  begin mul_a = MUL_AW'(period_q); mul_b = period_q; end
      ST_RMUL1: begin mul_a = MUL_AW'(r_len_q - r_e_q); mul_b = r_from_q; end
      ST_RMUL2: begin mul_a = MUL_AW'(r_e_q); mul_b = r_to_q; end
      ST_GMUL:  begin mul_a = MUL_AW'(osc_mag_q); mul_b = voice_gain_q; end
      ST_AMUL:  begin mul_a = acc_q[MUL_AW-1:0]; mul_b = amp_q; end
      ST_SDIV: begin
        if (wave_q == WAVE_SINE) begin
          div_num = {sq_q, 20'd0};
          div_den = sden_q;
        end else begin
          div_num = DIV_NW'({phase_q, 16'd0});
          div_den = DIV_DW'(period_q);
        end
      end
      ST_RDIV: begin
        div_num = DIV_NW'(acc_q[LEVEL_W+LEN_W:0]);
        div_den = DIV_DW'(r_len_q);
      end
      default: ;
    endcase
  end

  assign mul_start = !issued_q && ((state_q == ST_QMUL) || (state_q == ST_LMUL) ||
                     (state_q == ST_RMUL1) || (state_q == ST_RMUL2) ||
                     (state_q == ST_GMUL) || (state_q == ST_AMUL));
  assign div_start = !issued_q && ((state_q == ST_SDIV) || (state_q == ST_RDIV));

  // ---------------- envelope step setup ----------------
  logic [WW-1:0]    c_w, a_w, d_w, r_w, rs_w, e_raw, len_w;
  logic [LEN_W-1:0] e_clamp;

  always_comb begin
    c_w  = WW'(count_q);
    a_w  = WW'(len_of(attack_length_q));
    d_w  = WW'(len_of(decay_length_q));
    r_w  = WW'(len_of(release_length_q));
    rs_w = WW'(rstart_q);
    unique case (env_q)
      ENV_ATTACK: begin
        e_raw = c_w;
        len_w = a_w;
      end
      ENV_DECAY: begin
        e_raw = (c_w >= a_w) ? c_w - a_w : '0;
        len_w = d_w;
      end
      default: begin
        e_raw = (c_w >= rs_w) ? c_w - rs_w : '0;
        len_w = r_w;
      end
    endcase
    e_clamp = (e_raw > len_w) ? len_w[LEN_W-1:0] : e_raw[LEN_W-1:0];
  end

  // ---------------- sequencer ----------------
  logic [LFSR_W-1:0]  lfsr_next;
  logic [MUL_PW-1:0]  mag_sh, mag_sat;
  logic [MUL_PW-1:0]  sq5;
  logic               in_xfer, out_load;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_load  = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);
  assign lfsr_next = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_MASK : '0);
  assign mag_sh    = mul_prod >> SHIFT;
  assign sq5       = MUL_PW'(mul_prod[31:0]) * MUL_PW'(5);

  always_comb begin
    state_d      = state_q;
    issued_d     = issued_q;
    count_d      = count_q;
    phase_d      = phase_q;
    period_d     = period_q;
    wave_d       = wave_q;
    env_d        = env_q;
    rstart_d     = rstart_q;
    pend_d       = pend_q;
    lfsr_d       = lfsr_q;
    osc_mag_d    = osc_mag_q;
    osc_neg_d    = osc_neg_q;
    amp_d        = amp_q;
    stage_now_d  = stage_now_q;
    r_from_d     = r_from_q;
    r_to_d       = r_to_q;
    r_len_d      = r_len_q;
    r_e_d        = r_e_q;
    acc_d        = acc_q;
    sq_d         = sq_q;
    sden_d       = sden_q;
    res_d        = res_q;
    out_sample_d = out_sample_q;
    out_stage_d  = out_stage_q;
    mag_sat      = '0;
    out_valid_d  = (m_axis_tready) ? 1'b0 : out_valid_q;

    if (mul_start || div_start) begin
      issued_d = 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          priority case (s_axis_tuser)
            OP_NOTE_ON: begin
              period_d = (s_axis_tdata[15:0] < 16'd2) ? 16'd2 : s_axis_tdata[15:0];
              wave_d   = s_axis_tdata[17:16];
              count_d  = '0;
              phase_d  = '0;
              rstart_d = '0;
              env_d    = ENV_ATTACK;
              pend_d   = 1'b0;
            end
            OP_RELEASE: pend_d = 1'b1;
            OP_TICK:    state_d = ST_OSC;
            default: ;
          endcase
        end
      end

      // oscillator: direct forms here, divided forms through the divider
      ST_OSC: begin
        stage_now_d = env_q;
        issued_d    = 1'b0;
        unique case (wave_q)
          WAVE_SQUARE: begin
            osc_mag_d = 17'd32768;
            osc_neg_d = !(phase_q <= (period_q >> 1));
            state_d   = ST_ENV;
          end
          WAVE_SAW:  state_d = ST_SDIV;
          WAVE_SINE: state_d = ST_QMUL;
          default: begin
            lfsr_d = lfsr_next;
            if (lfsr_next[31]) begin
              osc_mag_d = {2'b0, lfsr_next[30:16]};
              osc_neg_d = 1'b0;
            end else begin
              osc_mag_d = 17'd32768 - 17'(lfsr_next[31:16]);
              osc_neg_d = 1'b1;
            end
            state_d = ST_ENV;
          end
        endcase
      end

      ST_QMUL: if (mul_done) begin
        sq_d     = mul_prod[31:0];
        issued_d = 1'b0;
        state_d  = ST_LMUL;
      end

      // 5*L^2 - 4*p*(L-p)
      ST_LMUL: if (mul_done) begin
        sden_d   = DIV_DW'(sq5) - DIV_DW'({sq_q, 2'b00});
        issued_d = 1'b0;
        state_d  = ST_SDIV;
      end

      ST_SDIV: if (div_done) begin
        if (div_quot[16] || div_quot[15]) begin
          osc_mag_d = div_quot - 17'd32768;
          osc_neg_d = 1'b0;
        end else begin
          osc_mag_d = 17'd32768 - div_quot;
          osc_neg_d = 1'b1;
        end
        issued_d = 1'b0;
        state_d  = ST_ENV;
      end

      // envelope amplitude source and stage transition
      ST_ENV: begin
        issued_d = 1'b0;
        r_len_d  = len_w[LEN_W-1:0];
        r_e_d    = e_clamp;
        unique case (env_q)
          ENV_ATTACK: begin
            r_from_d = '0;
            r_to_d   = attack_level_q;
            state_d  = ST_RMUL1;
            if (c_w >= a_w) begin
              env_d = ENV_DECAY;
            end else if (pend_q) begin
              env_d = ENV_RELEASE; rstart_d = count_q; pend_d = 1'b0;
            end
          end
          ENV_DECAY: begin
            r_from_d = attack_level_q;
            r_to_d   = decay_level_q;
            state_d  = ST_RMUL1;
            if (c_w >= a_w + d_w) begin
              env_d = ENV_SUSTAIN;
            end else if (pend_q) begin
              env_d = ENV_RELEASE; rstart_d = count_q; pend_d = 1'b0;
            end
          end
          ENV_SUSTAIN: begin
            amp_d   = sustain_level_q;
            state_d = ST_GMUL;
            if (pend_q) begin
              env_d = ENV_RELEASE; rstart_d = count_q; pend_d = 1'b0;
            end
          end
          ENV_RELEASE: begin
            r_from_d = sustain_level_q;
            r_to_d   = release_level_q;
            state_d  = ST_RMUL1;
            if (c_w >= rs_w + r_w) env_d = ENV_END;
          end
          default: begin
            amp_d   = release_level_q;
            state_d = ST_GMUL;
          end
        endcase
      end

      ST_RMUL1: if (mul_done) begin
        acc_d    = mul_prod;
        issued_d = 1'b0;
        state_d  = ST_RMUL2;
      end

      ST_RMUL2: if (mul_done) begin
        acc_d    = acc_q + mul_prod;
        issued_d = 1'b0;
        state_d  = ST_RDIV;
      end

      ST_RDIV: if (div_done) begin
        amp_d    = div_quot[LEVEL_W-1:0];
        issued_d = 1'b0;
        state_d  = ST_GMUL;
      end

      ST_GMUL: if (mul_done) begin
        acc_d    = mul_prod;
        issued_d = 1'b0;
        state_d  = ST_AMUL;
      end

      // scale, then saturate to the signed sample range
      ST_AMUL: if (mul_done) begin
        if (osc_neg_q) begin
          mag_sat = (mag_sh > LIM) ? LIM : mag_sh;
          res_d   = SW'(MUL_PW'(0) - mag_sat);
        end else begin
          mag_sat = (mag_sh > LIM - 1'b1) ? LIM - 1'b1 : mag_sh;
          res_d   = mag_sat[SW-1:0];
        end
        issued_d = 1'b0;
        state_d  = ST_OUT;
      end

      // hand the sample to the output register, advance the counter
      ST_OUT: if (out_load) begin
        out_valid_d  = 1'b1;
        out_sample_d = res_q;
        out_stage_d  = stage_now_q;
        if (count_q != COUNT_MAX) begin
          count_d = count_q + 1'b1;
          phase_d = (phase_q + 1'b1 == period_q) ? '0 : phase_q + 1'b1;
        end
        state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      count_q     <= '0;
      phase_q     <= '0;
      period_q    <= 16'd2;
      wave_q      <= WAVE_SQUARE;
      env_q       <= ENV_END;
      rstart_q    <= '0;
      pend_q      <= 1'b0;
      lfsr_q      <= LFSR_SEED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      count_q     <= count_d;
      phase_q     <= phase_d;
      period_q    <= period_d;
      wave_q      <= wave_d;
      env_q       <= env_d;
      rstart_q    <= rstart_d;
      pend_q      <= pend_d;
      lfsr_q      <= lfsr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working payload registers
  always_ff @(posedge clk_i) begin
    osc_mag_q    <= osc_mag_d;
    osc_neg_q    <= osc_neg_d;
    amp_q        <= amp_d;
    stage_now_q  <= stage_now_d;
    r_from_q     <= r_from_d;
    r_to_q       <= r_to_d;
    r_len_q      <= r_len_d;
    r_e_q        <= r_e_d;
    acc_q        <= acc_d;
    sq_q         <= sq_d;
    sden_q       <= sden_d;
    res_q        <= res_d;
    out_sample_q <= out_sample_d;
    out_stage_q  <= out_stage_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDW'({out_stage_q, out_sample_q});

`ifndef SYNTH
  // the two serial units are never busy at once
  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_busy && div_busy))
    else $error("multiplier and divider busy together");

  // oscillator phase stays inside the period
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q < period_q)
    else $error("oscillator phase out of range");

  // each delivered sample advances the unsaturated sample counter by one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (count_q != COUNT_MAX)) |=> (count_q == $past(count_q) + 1'b1))
    else $error("sample counter did not advance");

  // an item is only taken while the sequencer is not working on a tick
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_busy || div_busy) |-> !s_axis_tready)
    else $error("item accepted during tick processing");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for oscillator_adsr_voice_unit: note on, release and tick items
// are streamed in, and every sample is checked against an in-bench voice predictor.
// Depends on oav_pkg and the voice RTL.
`default_nettype none

module tb;
  import oav_pkg::*;

  localparam int unsigned SW = SAMPLE_WIDTH_DEF;
  localparam int unsigned OUT_TDW = ((SW + STAGE_W + 7) / 8) * 8;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [SW-1:0]      sample;
    logic [STAGE_W-1:0] stage;
  } voice_sample_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // note_period[15:0], wave_select[17:16]
  logic [OP_W-1:0] s_axis_tuser = '0; // op[1:0]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDW-1:0] m_axis_tdata; // sample_out[15:0], stage[18:16]
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  oscillator_adsr_voice_unit u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of registers and voice state
  logic [63:0] atk_lvl, atk_len, dec_lvl, dec_len, sus_lvl, rel_lvl, rel_len, gain;
  logic [63:0] count_q, period_q, rel_start_q;
  logic [WAVE_W-1:0] wave_q;
  env_stage_e stage_q;
  logic pending_q;
  logic [31:0] lfsr_q;

  voice_sample_t expected_samples[$];
  int errors = 0;
  int samples_seen = 0;
  int items_sent = 0;
  bit idle_en = 1'b1;
  int hold_cycles = 0;
  longint cycles = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0d want %0d (sample %0d)", what, got, want, samples_seen);
    errors++;
  endtask

  function automatic logic [63:0] ramp(input logic [63:0] from, input logic [63:0] to,
                                       input logic [63:0] e, input logic [63:0] len);
    if (e > len) e = len;
    return (from * (len - e) + to * e) / len;
  endfunction

  function automatic logic [63:0] nz(input logic [63:0] v);
    return (v == 0) ? 64'd1 : v;
  endfunction

  function automatic void take_rel();
    stage_q = ENV_RELEASE;
    rel_start_q = count_q;
    pending_q = 1'b0;
  endfunction

  // Works out one sample and advances the voice
  function automatic voice_sample_t voice_tick();
    voice_sample_t r;
    longint osc;
    logic [63:0] p, q, amp, mag, lim, a, d, rl;
    r.stage = stage_q;
    p = count_q % period_q;
    case (wave_q)
      WAVE_SQUARE: osc = (p <= period_q / 2) ? 32768 : -32768;
      WAVE_SAW:    osc = longint'((p * 65536) / period_q) - 32768;
      WAVE_SINE: begin
        q = p * (period_q - p);
        osc = longint'((q * 16 * 65536) / (5 * period_q * period_q - 4 * q)) - 32768;
      end
      default: begin
        lfsr_q = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_MASK : 32'd0);
        osc = longint'(lfsr_q >> 16) - 32768;
      end
    endcase
    a = nz(atk_len); d = nz(dec_len); rl = nz(rel_len);
    case (stage_q)
      ENV_ATTACK: begin
        amp = ramp(0, atk_lvl, count_q, a);
        if (count_q + 1 > a) stage_q = ENV_DECAY;
        else if (pending_q) take_rel();
      end
      ENV_DECAY: begin
        amp = ramp(atk_lvl, dec_lvl, count_q >= a ? count_q - a : 0, d);
        if (count_q + 1 > a + d) stage_q = ENV_SUSTAIN;
        else if (pending_q) take_rel();
      end
      ENV_SUSTAIN: begin
        if (pending_q) take_rel();
        amp = sus_lvl;
      end
      ENV_RELEASE: begin
        amp = ramp(sus_lvl, rel_lvl,
                   count_q >= rel_start_q ? count_q - rel_start_q : 0, rl);
        if (count_q + 1 > rel_start_q + rl) stage_q = ENV_END;
      end
      default: amp = rel_lvl;
    endcase
    mag = 64'(osc < 0 ? -osc : osc) * gain * amp;
    q = mag >> (46 - SW);
    lim = 64'd1 << (SW - 1);
    if (osc < 0) begin
      if (q > lim) q = lim;
      r.sample = SW'(0 - q);
    end else begin
      if (q > lim - 1) q = lim - 1;
      r.sample = SW'(q);
    end
    if (count_q < 64'hFFFF_FFFF) count_q++;
    return r;
  endfunction

  // Applies one accepted item to the predictor
  function automatic void predict_item(input logic [OP_W-1:0] op, input logic [15:0] per,
                                       input logic [WAVE_W-1:0] wv);
    if (op == OP_NOTE_ON) begin
      period_q = (per < 2) ? 64'd2 : 64'(per);
      wave_q = wv;
      count_q = 0;
      rel_start_q = 0;
      stage_q = ENV_ATTACK;
      pending_q = 1'b0;
    end else if (op == OP_RELEASE) begin
      pending_q = 1'b1;
    end else if (op == OP_TICK) begin
      expected_samples.push_back(voice_tick());
    end
  endfunction

  // Sends one item, waiting for its transfer; valid stays up for back-to-back items
  task automatic send_item(input logic [OP_W-1:0] op, input logic [15:0] per = 16'd0,
                           input logic [WAVE_W-1:0] wv = '0);
    while (idle_en && $urandom_range(99) < 35) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {6'd0, wv, per};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_item(op, per, wv);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  // Register write, only called with the voice idle
  task automatic write_reg(input logic [REG_AW-1:0] idx, input logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_ATTACK_LEVEL:   atk_lvl = val[15:0];
      REG_ATTACK_LENGTH:  atk_len = val[23:0];
      REG_DECAY_LEVEL:    dec_lvl = val[15:0];
      REG_DECAY_LENGTH:   dec_len = val[23:0];
      REG_SUSTAIN_LEVEL:  sus_lvl = val[15:0];
      REG_RELEASE_LEVEL:  rel_lvl = val[15:0];
      REG_RELEASE_LENGTH: rel_len = val[23:0];
      default:            gain = val[15:0];
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_envelope(input logic [31:0] al, input logic [31:0] alen,
                              input logic [31:0] dl, input logic [31:0] dlen,
                              input logic [31:0] sl, input logic [31:0] rlv,
                              input logic [31:0] rlen, input logic [31:0] g);
    wait_drained();
    write_reg(REG_ATTACK_LEVEL, al);
    write_reg(REG_ATTACK_LENGTH, alen);
    write_reg(REG_DECAY_LEVEL, dl);
    write_reg(REG_DECAY_LENGTH, dlen);
    write_reg(REG_SUSTAIN_LEVEL, sl);
    write_reg(REG_RELEASE_LEVEL, rlv);
    write_reg(REG_RELEASE_LENGTH, rlen);
    write_reg(REG_VOICE_GAIN, g);
  endtask

  // Checks each sample transfer against the oldest expectation
  always @(posedge clk_i) begin
    voice_sample_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = voice_sample_t'({m_axis_tdata[SW-1:0], m_axis_tdata[SW+STAGE_W-1:SW]});
      if (expected_samples.size() == 0) begin
        report("unexpected sample", got.sample, 0);
      end else begin
        want = expected_samples.pop_front();
        if (got.sample !== want.sample) report("sample_out", got.sample, want.sample);
        if (got.stage !== want.stage) report("stage", got.stage, want.stage);
      end
      samples_seen++;
    end
  end

  // Receiver readiness, with random stalls and one long hold-off
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(idle_en && $urandom_range(99) < 35);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic test_directed_waves();
    logic [WAVE_W-1:0] wv;
    send_item(OP_TICK);                       // tick before any note: end stage
    send_item(OP_UNKNOWN, 16'hFFFF, 2'd3);    // unknown op is dropped
    for (int w = 0; w < 4; w++) begin
      wv = WAVE_W'(w);
      send_item(OP_NOTE_ON, (w == 0) ? 16'd0 : (w == 3 ? 16'hFFFF : 16'd5), wv);
      repeat (3) send_item(OP_TICK);
    end
    send_item(OP_NOTE_ON, 16'd1, WAVE_SAW);   // short period taken as two
    send_item(OP_TICK);
    send_item(OP_RELEASE);
    send_item(OP_TICK);
    send_item(OP_TICK);
  endtask

  task automatic test_envelope_walk(input int notes, input int max_ticks);
    int n;
    for (int k = 0; k < notes; k++) begin
      send_item(OP_NOTE_ON, 16'($urandom_range(2, ($urandom_range(3) == 0) ? 65535 : 40)),
                WAVE_W'($urandom_range(3)));
      n = $urandom_range(2, max_ticks);
      for (int t = 0; t < n; t++) begin
        if ($urandom_range(19) == 0) send_item(OP_RELEASE);
        else if ($urandom_range(49) == 0)
          send_item(OP_TICK + OP_W'($urandom_range(3)), 16'($urandom), WAVE_W'($urandom));
        else send_item(OP_TICK);
      end
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 600;
    repeat (12) send_item(OP_TICK);
  endtask

  initial begin
    atk_lvl = 32768; atk_len = 4800; dec_lvl = 16384; dec_len = 4800;
    sus_lvl = 16384; rel_lvl = 0; rel_len = 4800; gain = 32768;
    count_q = 0; period_q = 2; wave_q = WAVE_SQUARE; stage_q = ENV_END;
    rel_start_q = 0; pending_q = 1'b0; lfsr_q = LFSR_SEED;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_waves();
    // extremes: full levels, zero lengths, max gain
    set_envelope(32'hFFFF, 0, 32'hFFFF, 0, 32'hFFFF, 32'hFFFF, 0, 32'hFFFF);
    test_directed_waves();
    set_envelope(0, 32'hFFFFFF, 0, 32'hFFFFFF, 0, 0, 32'hFFFFFF, 0);
    test_envelope_walk(2, 6);
    // short ramps so stages are crossed often
    set_envelope(40000, 3, 20000, 4, 12000, 3000, 5, 50000);
    test_envelope_walk(24, 20);
    test_backpressure();
    idle_en = 1'b0;                           // stretch with no idling
    test_envelope_walk(5, 20);
    idle_en = 1'b1;
    set_envelope($urandom_range(65535), $urandom_range(1, 12), $urandom_range(65535),
                 $urandom_range(1, 12), $urandom_range(65535), $urandom_range(65535),
                 $urandom_range(1, 12), $urandom_range(65535));
    test_envelope_walk(16, 24);

    wait_drained();
    $display("covered %0d items and %0d samples: all waves, every stage, zero and full",
             items_sent, samples_seen);
    $display("register settings, unknown ops and a long output stall");
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule

`default_nettype wire
